FILE: src/cmr_pkg.sv
// Shared types and constants for the coprocessor MMIO router.
package cmr_pkg;

  localparam int unsigned SEM_COUNT       = 8;
  localparam int unsigned SEM_DEPTH       = 8;
  localparam int unsigned SEM_IDX_W       = 3;
  localparam int unsigned LOCAL_MEM_BYTES = 16384;

  // Address windows
  localparam logic [26:0] SEM_WIN_HI     = 27'(32'hFFE80020 >> 5);
  localparam logic [25:0] MOP_WIN_HI     = 26'(32'hFFB80000 >> 6);
  localparam logic [5:0]  MOP_WIN_LAST   = 6'h23;
  localparam logic [19:0] RF_WIN_HI      = 20'hFFE00;
  localparam logic [26:0] PC_WIN_HI      = 27'(32'hFFE80000 >> 5);
  localparam logic [13:0] INSTR_WIN_HI   = 14'(32'hFFE40000 >> 18);
  localparam logic [13:0] STREAM_WIN_HI  = 14'(32'hFFB40000 >> 18);
  localparam logic [11:0] STREAM_UPD_REG = 12'h438;
  localparam logic [31:0] STREAM_BASE    = 32'hFFB00000;
  localparam logic [21:0] STREAM_AVAIL   = 22'h6C;

  // Local memory offsets
  localparam logic [13:0] MOP_OFF_BASE = 14'h2000;
  localparam logic [13:0] RF_OFF_BASE  = 14'h2100;
  localparam logic [13:0] PC_OFF_BASE  = 14'h3100;

  localparam logic [3:0] SEM_MAX_VAL  = 4'd15;
  localparam logic [2:0] CORE_MASTER  = 3'b111;

  typedef enum logic [2:0] {
    ROUTE_NORMAL    = 3'd0,
    ROUTE_SEMAPHORE = 3'd1,
    ROUTE_LOCAL     = 3'd2,
    ROUTE_PUSH      = 3'd3,
    ROUTE_IREAD     = 3'd4,
    ROUTE_IGNORED   = 3'd5,
    ROUTE_STREAM    = 3'd6
  } route_t;

  typedef struct packed {
    logic        action;
    logic [2:0]  core;
    logic [31:0] address;
    logic [31:0] write_data;
  } req_t;

  typedef struct packed {
    logic        handled;
    route_t      route;
    logic [31:0] read_data;
    logic [13:0] local_offset;
    logic        mop_write;
    logic [3:0]  mop_index;
    logic [1:0]  push_thread;
    logic [21:0] stream_offset;
    logic [16:0] stream_increment;
  } result_t;

  typedef struct packed {
    logic                 we;
    logic [SEM_IDX_W-1:0] idx;
    logic [3:0]           wdata;
  } sem_upd_t;

endpackage

FILE: src/cmr_decode.sv
// Address window decode and routing result for one bus access.
module cmr_decode (
  input  cmr_pkg::req_t    req,
  input  logic [3:0]       sem_value,
  output cmr_pkg::result_t res,
  output cmr_pkg::sem_upd_t sem_upd
);

  logic [31:0] a;
  logic [31:0] d;
  logic        wr;
  logic        thread_core;
  logic        master_core;
  logic        sem_hit;
  logic        mop_hit;
  logic        rf_hit;
  logic        pc_hit;
  logic        local_hit;
  logic [13:0] off;
  logic        off_ok;
  logic        instr_hit;
  logic [1:0]  win;
  logic        stream_upd;
  logic [31:0] stream_rel;

  always_comb begin
    a  = req.address;
    d  = req.write_data;
    wr = req.action;
    thread_core = !req.core[2] && (req.core[1:0] != 2'd3);
    master_core = (req.core == cmr_pkg::CORE_MASTER);

    sem_hit = (a[31:5] == cmr_pkg::SEM_WIN_HI)
              && ({1'b0, a[4:2]} < 4'(cmr_pkg::SEM_COUNT));
    mop_hit = (a[31:6] == cmr_pkg::MOP_WIN_HI) && (a[5:0] <= cmr_pkg::MOP_WIN_LAST);
    rf_hit  = (a[31:12] == cmr_pkg::RF_WIN_HI);
    pc_hit  = (a[31:5] == cmr_pkg::PC_WIN_HI);
    local_hit = mop_hit || rf_hit || pc_hit;

    if (mop_hit)     off = cmr_pkg::MOP_OFF_BASE + {8'd0, a[5:0]};
    else if (rf_hit) off = cmr_pkg::RF_OFF_BASE + {2'd0, a[11:0]};
    else             off = cmr_pkg::PC_OFF_BASE + {9'd0, a[4:0]};
    off_ok = ({3'd0, off} < 17'(cmr_pkg::LOCAL_MEM_BYTES));

    instr_hit = (a[31:18] == cmr_pkg::INSTR_WIN_HI) && (a[17:16] != 2'd3);
    win       = a[17:16];

    stream_upd = wr && (a[31:18] == cmr_pkg::STREAM_WIN_HI)
                 && (a[11:0] == cmr_pkg::STREAM_UPD_REG);
    stream_rel = a - cmr_pkg::STREAM_BASE;

    res = '0;
    sem_upd.we    = 1'b0;
    sem_upd.idx   = a[4:2];
    sem_upd.wdata = d[3:0];

    if (sem_hit) begin
      res.handled = 1'b1;
      res.route   = cmr_pkg::ROUTE_SEMAPHORE;
      if (wr) begin
        sem_upd.we = 1'b1;
        if (d == 32'd0) begin
          sem_upd.wdata = (sem_value == cmr_pkg::SEM_MAX_VAL) ? sem_value
                                                              : sem_value + 4'd1;
        end else if (d == 32'd1) begin
          sem_upd.wdata = (sem_value == 4'd0) ? sem_value : sem_value - 4'd1;
        end
      end else begin
        res.read_data = {28'd0, sem_value};
      end
    end else if (thread_core && local_hit && (wr || off_ok)) begin
      res.handled = 1'b1;
      res.route   = cmr_pkg::ROUTE_LOCAL;
      if (off_ok) res.local_offset = off;
      if (wr && mop_hit) begin
        res.mop_write = 1'b1;
        res.mop_index = a[5:2];
      end
    end else if (instr_hit) begin
      res.handled = 1'b1;
      if (!wr) begin
        res.route = cmr_pkg::ROUTE_IREAD;
      end else if (win == 2'd0 && thread_core) begin
        res.route       = cmr_pkg::ROUTE_PUSH;
        res.push_thread = req.core[1:0];
      end else if (master_core) begin
        res.route       = cmr_pkg::ROUTE_PUSH;
        res.push_thread = win;
      end else begin
        res.route = cmr_pkg::ROUTE_IGNORED;
      end
    end else if (stream_upd) begin
      // normal write still proceeds, so not handled
      res.route            = cmr_pkg::ROUTE_STREAM;
      res.stream_increment = d[22:6];
      res.stream_offset    = stream_rel[21:0] + cmr_pkg::STREAM_AVAIL;
    end
  end

endmodule

FILE: src/coprocessor_mmio_router_core.sv
// Top level of the coprocessor MMIO router: semaphore bank, decode and result register.
//
//  channel   | dir | tdata (low bit up)                                   | tuser
//  ----------+-----+-------------------------------------------------------+-----------
//  s_axis    | in  | core[2:0], address[31:0], write_data[31:0], 0 pad     | action
//  m_axis    | out | handled, read_data, local_offset, mop_write,          | route
//            |     | mop_index, push_thread, stream_offset,                |
//            |     | stream_increment, 0 pad                               |
//
// One item per clock. An accepted item is decoded in the cycle it arrives and its
// result sits in the output register on the next cycle; the semaphore read-modify-
// write happens at the same accept edge, so a following item sees the new value.
// The output register is the only stage: s_axis_tready drops only while a result
// is held and m_axis_tready is low. rst clears the semaphores and the output valid.
module coprocessor_mmio_router_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [71:0] s_axis_tdata,  // core[2:0], address[34:3], write_data[66:35]
  input  logic        s_axis_tuser,  // action: 0 read, 1 write
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [95:0] m_axis_tdata,  // handled[0], read_data[32:1], local_offset[46:33],
                                     // mop_write[47], mop_index[51:48],
                                     // push_thread[53:52], stream_offset[75:54],
                                     // stream_increment[92:76]
  output logic [2:0]  m_axis_tuser   // route
);

  cmr_pkg::req_t     req;
  cmr_pkg::result_t  res;
  cmr_pkg::result_t  out_res;
  cmr_pkg::sem_upd_t sem_upd;
  logic [3:0]        sem_bank [cmr_pkg::SEM_DEPTH];
  logic [3:0]        sem_value;
  logic              accept;

  always_comb begin
    req.action     = s_axis_tuser;
    req.core       = s_axis_tdata[2:0];
    req.address    = s_axis_tdata[34:3];
    req.write_data = s_axis_tdata[66:35];
  end

  // bank read at the requested word; decode gates it with the window match
  assign sem_value = sem_bank[req.address[4:2]];

  cmr_decode u_decode (
    .req      (req),
    .sem_value(sem_value),
    .res      (res),
    .sem_upd  (sem_upd)
  );

  assign s_axis_tready = !m_axis_tvalid || m_axis_tready;
  assign accept        = s_axis_tvalid && s_axis_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      sem_bank <= '{default: 4'd0};
    end else if (accept && sem_upd.we) begin
      sem_bank[sem_upd.idx] <= sem_upd.wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (s_axis_tready) begin
      m_axis_tvalid <= s_axis_tvalid;
    end
  end

  // payload register, no reset needed
  always_ff @(posedge clk) begin
    if (accept) begin
      out_res <= res;
    end
  end

  assign m_axis_tdata = {3'd0,
                         out_res.stream_increment,
                         out_res.stream_offset,
                         out_res.push_thread,
                         out_res.mop_index,
                         out_res.mop_write,
                         out_res.local_offset,
                         out_res.read_data,
                         out_res.handled};
  assign m_axis_tuser = out_res.route;

endmodule
